### hw/rtl/kgd_pkg.sv
package kgd_pkg;

  localparam int CNT_W   = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] CLICK_WINDOW_RST = 16'd50;
  localparam logic [CNT_W-1:0] HOLD_PERIOD_RST  = 16'd100;
  localparam logic [CNT_W-1:0] CNT_MAX          = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLICK_WINDOW = 2'd0,
    CFG_HOLD_PERIOD  = 2'd1
  } cfg_idx_t;

  // Events and count produced for one tick.
  typedef struct packed {
    logic             press;
    logic             release_ev;
    logic             click;
    logic             hold;
    logic [CNT_W-1:0] hold_count;
  } kgd_result_t;

endpackage

### hw/rtl/kgd_core.sv
module kgd_core import kgd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 step_en,
  input  logic                 key_level,
  output kgd_result_t          result
);

  logic [CNT_W-1:0] click_window_r;
  logic [CNT_W-1:0] hold_period_r;
  logic             last_level_r;
  logic [CNT_W-1:0] click_rem_r;
  logic [CNT_W-1:0] hold_rem_r;
  logic [CNT_W-1:0] repeat_cnt_r;

  logic             last_level_nxt;
  logic [CNT_W-1:0] click_rem_nxt;
  logic [CNT_W-1:0] hold_rem_nxt;
  logic [CNT_W-1:0] repeat_cnt_nxt;
  logic [CNT_W-1:0] click_a;
  logic [CNT_W-1:0] hold_a;
  logic [CNT_W-1:0] cnt_a;

  always_comb begin
    click_a = click_rem_r;
    hold_a  = hold_rem_r;
    cnt_a   = repeat_cnt_r;
    result  = '0;

    // Level change: press reloads both timers, release cancels the hold.
    if (key_level != last_level_r) begin
      if (!key_level) begin
        result.press = 1'b1;
        click_a = click_window_r;
        hold_a  = hold_period_r;
        cnt_a   = '0;
      end else begin
        result.release_ev = 1'b1;
        hold_a = '0;
        cnt_a  = '0;
        if (click_rem_r > CNT_W'(1)) begin
          result.click = 1'b1;
          click_a = '0;
        end
      end
    end

    // Hold period expiry, with a saturating repeat count.
    if (hold_a == CNT_W'(1)) begin
      result.hold = 1'b1;
      hold_a = hold_period_r;
      if (cnt_a != CNT_MAX) begin
        cnt_a = cnt_a + CNT_W'(1);
      end
    end

    result.hold_count = cnt_a;

    if (click_a > CNT_W'(1)) begin
      click_a = click_a - CNT_W'(1);
    end
    if (hold_a > CNT_W'(1)) begin
      hold_a = hold_a - CNT_W'(1);
    end

    last_level_nxt = key_level;
    click_rem_nxt  = click_a;
    hold_rem_nxt   = hold_a;
    repeat_cnt_nxt = cnt_a;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      click_window_r <= CLICK_WINDOW_RST;
      hold_period_r  <= HOLD_PERIOD_RST;
      last_level_r   <= 1'b1;
      click_rem_r    <= '0;
      hold_rem_r     <= '0;
      repeat_cnt_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_CLICK_WINDOW: click_window_r <= cfg_wdata;
          CFG_HOLD_PERIOD:  hold_period_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (step_en) begin
        last_level_r <= last_level_nxt;
        click_rem_r  <= click_rem_nxt;
        hold_rem_r   <= hold_rem_nxt;
        repeat_cnt_r <= repeat_cnt_nxt;
      end
    end
  end

  a_click_needs_release: assert property (@(posedge clk) disable iff (!rst_n)
    result.click |-> result.release_ev)
    else $error("click without release");

  a_no_hold_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    result.release_ev |-> (!result.hold && result.hold_count == '0))
    else $error("hold activity on release tick");

  a_press_count: assert property (@(posedge clk) disable iff (!rst_n)
    result.press |-> (result.hold_count == CNT_W'(result.hold)))
    else $error("hold count not restarted on press");

  a_count_held: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && !result.hold && !result.press && !result.release_ev)
      |=> $stable(repeat_cnt_r))
    else $error("repeat count moved without a hold event");

endmodule

### hw/rtl/key_gesture_detector.sv
// Key gesture detector.
// Each input transaction is one timer tick carrying the debounced, active-low
// key level (0 pressed, 1 released). For every input transaction the block
// returns exactly one output transaction with press, release, click and hold
// pulses for that tick, plus the running hold repeat count (saturating).
// Two configuration registers, click window (index 0) and hold period
// (index 1), are written through the cfg_ port; a new value takes effect the
// next time the matching timer is loaded (a press for both, and every hold
// event as well for the hold period).
// The tick is captured in an input register, evaluated by the gesture logic
// and captured in the output register. Throughput is one transaction per
// cycle while the receiver does not stall; the gesture state update is a
// single compare and decrement step, so ticks can follow back to back.
// When the receiver stalls, the output register holds its transaction and the
// input register can still take one more tick; in_stall rises only when both
// are full and the output stays stalled.
// Synchronous reset clears both pipeline registers, restores the register
// defaults (50 and 100) and returns the key state to released with all timers
// and the hold count at zero.
module key_gesture_detector import kgd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_key_level,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_press_event,
  output logic                 out_release_event,
  output logic                 out_click_event,
  output logic                 out_hold_event,
  output logic [CNT_W-1:0]     out_hold_count
);

  logic        s1_valid_r;
  logic        s1_level_r;
  logic        out_valid_r;
  kgd_result_t out_res_r;
  kgd_result_t step_res;
  logic        out_free;
  logic        step_en;
  logic        in_take;

  // The output register is free when empty or being drained this cycle.
  assign out_free = !out_valid_r || !out_stall;
  // The captured tick is evaluated and its state committed as it moves on.
  assign step_en  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  kgd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step_en   (step_en),
    .key_level (s1_level_r),
    .result    (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (step_en) begin
        s1_valid_r <= 1'b0;
      end
      if (step_en) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_take) begin
      s1_level_r <= in_key_level;
    end
    if (step_en) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_press_event   = out_res_r.press;
  assign out_release_event = out_res_r.release_ev;
  assign out_click_event   = out_res_r.click;
  assign out_hold_event    = out_res_r.hold;
  assign out_hold_count    = out_res_r.hold_count;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_res_r)))
    else $error("stalled output transaction changed");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with free pipeline space");

  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !step_en) |=> s1_valid_r)
    else $error("pending tick dropped");

endmodule

### dv/key_gesture_detector_tb.sv
`timescale 1ns / 1ps

module key_gesture_detector_tb;
  import kgd_pkg::*;

  // This many quiet cycles after the last result are plenty before touching a
  // register or ending the run.
  localparam int SETTLE_CYCLES = 4;
  // No transaction on either channel for this many cycles means the block hung.
  localparam int WATCHDOG_CYCLES = 2000;
  // The register file decodes two indexes; this one has no register behind it.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_key_level = 1'b1;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_press_event;
  logic                 out_release_event;
  logic                 out_click_event;
  logic                 out_hold_event;
  logic [CNT_W-1:0]     out_hold_count;

  key_gesture_detector u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_key_level      (in_key_level),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_press_event   (out_press_event),
    .out_release_event (out_release_event),
    .out_click_event   (out_click_event),
    .out_hold_event    (out_hold_event),
    .out_hold_count    (out_hold_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Percent of ticks sent after a sender gap, and of cycles the receiver stalls.
  int unsigned feed_gap_pct = 30;
  int unsigned drain_stall_pct = 30;

  int unsigned mismatches = 0;
  int unsigned ticks_sent = 0;
  int unsigned quiet_cycles = 0;

  // Events expected for ticks that went in but have not come out yet.
  kgd_result_t pending_events[$];

  // Our own copy of the register file and of the gesture state.
  logic [CNT_W-1:0] click_win = CLICK_WINDOW_RST;
  logic [CNT_W-1:0] hold_per  = HOLD_PERIOD_RST;
  logic             key_state = 1'b1;
  logic [CNT_W-1:0] click_left = '0;
  logic [CNT_W-1:0] hold_left = '0;
  logic [CNT_W-1:0] repeats = '0;

  // Advances the gesture state by one tick and returns the events of that
  // tick. Level changes come first, then the hold timer, then both timers
  // count down while they are above one.
  function automatic kgd_result_t advance_tick(input logic level);
    kgd_result_t ev;
    ev = '0;
    if (level != key_state) begin
      key_state = level;
      if (!level) begin
        ev.press = 1'b1;
        click_left = click_win;
        hold_left = hold_per;
        repeats = '0;
      end else begin
        ev.release_ev = 1'b1;
        hold_left = '0;
        repeats = '0;
        if (click_left > 1) begin
          ev.click = 1'b1;
          click_left = '0;
        end
      end
    end
    if (hold_left == 1) begin
      ev.hold = 1'b1;
      hold_left = hold_per;
      if (repeats != CNT_MAX) repeats = repeats + 1'b1;
    end
    if (click_left > 1) click_left = click_left - 1'b1;
    if (hold_left > 1) hold_left = hold_left - 1'b1;
    ev.hold_count = repeats;
    return ev;
  endfunction

  // Sends one tick. The valid stays high after acceptance so that back to
  // back ticks keep the channel busy; a gap lowers it first.
  task automatic send_tick(input logic level);
    int unsigned gap;
    gap = 0;
    if (feed_gap_pct != 0 && $urandom_range(99) < feed_gap_pct) gap = $urandom_range(1, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_key_level <= level;
    do @(posedge clk); while (in_stall);
    pending_events.push_back(advance_tick(level));
    ticks_sent++;
  endtask

  task automatic hold_level(input logic level, input int unsigned n);
    repeat (n) send_tick(level);
  endtask

  // Stops sending and waits until every outstanding tick has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
  endtask

  // Registers are only written with the pipeline empty and quiet.
  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_CLICK_WINDOW) click_win = data;
    else if (idx == CFG_HOLD_PERIOD) hold_per = data;
  endtask

  // Short hand-picked sequences: taps at the reset settings, click windows
  // too short to ever click, a window of three that just allows a click, the
  // unit hold period that fires on every held tick, a zero hold period that
  // never fires, the largest values of both registers, and a write to an
  // index without a register, which must change nothing.
  task automatic test_directed_gestures();
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);

    set_register(CFG_CLICK_WINDOW, 16'd0);
    set_register(CFG_HOLD_PERIOD, 16'd1);
    hold_level(1'b0, 3);
    send_tick(1'b1);

    set_register(CFG_CLICK_WINDOW, 16'd1);
    send_tick(1'b0);
    send_tick(1'b1);

    set_register(CFG_CLICK_WINDOW, 16'd3);
    set_register(CFG_HOLD_PERIOD, 16'd2);
    send_tick(1'b0);
    send_tick(1'b1);
    hold_level(1'b0, 3);
    send_tick(1'b1);

    set_register(CFG_HOLD_PERIOD, 16'd0);
    hold_level(1'b0, 3);
    send_tick(1'b1);

    set_register(CFG_CLICK_WINDOW, CNT_MAX);
    set_register(CFG_HOLD_PERIOD, CNT_MAX);
    send_tick(1'b0);
    send_tick(1'b1);

    set_register(CFG_UNUSED_IDX, 16'h0000);
    send_tick(1'b0);
    send_tick(1'b1);
  endtask

  // Holds the key at a unit hold period with both sides running flat out, so
  // the repeat count climbs by one on every tick. This is also the long
  // stretch without any idling.
  task automatic test_full_rate();
    feed_gap_pct = 0;
    drain_stall_pct = 0;
    set_register(CFG_CLICK_WINDOW, 16'd0);
    set_register(CFG_HOLD_PERIOD, 16'd1);
    hold_level(1'b0, 80);
    send_tick(1'b1);
    feed_gap_pct = 30;
    drain_stall_pct = 30;
  endtask

  // Mostly well-formed press/hold/release gestures of random length, with
  // some ticks of random level mixed in. Each phase runs with its own
  // register settings; in the middle of each the sender waits for the
  // pipeline to empty completely before going on.
  task automatic test_random_gestures();
    int unsigned phase_start;
    int unsigned dur;
    bit paused;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          set_register(CFG_CLICK_WINDOW, CLICK_WINDOW_RST);
          set_register(CFG_HOLD_PERIOD, HOLD_PERIOD_RST);
        end
        1: begin
          set_register(CFG_CLICK_WINDOW, 16'($urandom_range(0, 8)));
          set_register(CFG_HOLD_PERIOD, 16'd1);
        end
        2: begin
          set_register(CFG_CLICK_WINDOW, 16'($urandom_range(0, 65535)));
          set_register(CFG_HOLD_PERIOD, 16'($urandom_range(1, 65535)));
        end
        default: begin
          set_register(CFG_CLICK_WINDOW, 16'($urandom_range(0, 12)));
          set_register(CFG_HOLD_PERIOD, 16'($urandom_range(1, 15)));
        end
      endcase
      phase_start = ticks_sent;
      paused = 1'b0;
      while (ticks_sent - phase_start < 170) begin
        if ($urandom_range(99) < 85) begin
          // Large hold periods would make presses far too long; cap them.
          dur = (hold_per > 100) ? 60 : 3 * hold_per + 2;
          hold_level(1'b0, $urandom_range(1, dur));
          hold_level(1'b1, $urandom_range(1, 6));
        end else begin
          repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(0, 1)));
        end
        if (!paused && ticks_sent - phase_start >= 85) begin
          wait_drained();
          paused = 1'b1;
        end
      end
    end
  endtask

  // Receiver: compares each accepted result transaction with the oldest
  // expectation and stalls at random.
  always @(posedge clk) begin : result_check
    kgd_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        $error("result transaction with no tick outstanding");
        mismatches++;
      end else begin
        want = pending_events.pop_front();
        if (out_press_event !== want.press) begin
          $error("press_event: expected %0d, actual %0d", want.press, out_press_event);
          mismatches++;
        end
        if (out_release_event !== want.release_ev) begin
          $error("release_event: expected %0d, actual %0d", want.release_ev, out_release_event);
          mismatches++;
        end
        if (out_click_event !== want.click) begin
          $error("click_event: expected %0d, actual %0d", want.click, out_click_event);
          mismatches++;
        end
        if (out_hold_event !== want.hold) begin
          $error("hold_event: expected %0d, actual %0d", want.hold, out_hold_event);
          mismatches++;
        end
        if (out_hold_count !== want.hold_count) begin
          $error("hold_count: expected %0d, actual %0d", want.hold_count, out_hold_count);
          mismatches++;
        end
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < drain_stall_pct);
  end

  // Watchdog: any transaction on either channel restarts the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_CYCLES) begin
        $display("key_gesture_detector_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_gestures();
    test_full_rate();
    test_random_gestures();

    wait_drained();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("key_gesture_detector_tb: clean");
    end else begin
      $display("key_gesture_detector_tb: errors");
    end
    $finish;
  end

endmodule
